// ----- rtl/tcw_pkg.sv -----
// Shared constants, codes and controller/datapath interface structs
// for the text console character writer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

   // Screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int TAB_WIDTH  = 4;
   localparam int CELL_COUNT = ROWS * COLUMNS;

   // Internal widths
   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int TAB_W  = $clog2(TAB_WIDTH + 1);

   // Port field widths
   localparam int OP_W      = 2;
   localparam int CHAR_W    = 8;
   localparam int ATTR_W    = 8;
   localparam int REQ_ROW_W = 5;
   localparam int REQ_COL_W = 7;
   localparam int POS_W     = 11;
   localparam int CELL_W    = CHAR_W + ATTR_W;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

   // Control characters
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

   typedef enum logic [OP_W-1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_SET   = 2'd2,
      OP_READ  = 2'd3
   } tcw_op_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;
      logic put_char;
      logic put_space;
      logic newline;
      logic back_step;
      logic blank;
      logic cursor_jump;
      logic clear_start;
      logic clear_write;
      logic scroll_prime;
      logic scroll_copy;
      logic scroll_fill;
      logic read_issue;
      logic read_capture;
      logic respond;
   } tcw_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      tcw_op_type op;
      logic       is_tab;
      logic       is_newline;
      logic       is_backspace;
      logic       at_last_row;
      logic       at_last_cell;
      logic       copy_last;
      logic       sweep_last;
   } tcw_status_type;

   // Linear cell index of a row and column
   function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
      logic [ADDR_W-1:0] base;
      base = ADDR_W'(ADDR_W'(r) * ADDR_W'(COLUMNS));
      return base + ADDR_W'(c);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/tcw_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/tcw_dp.sv -----
// Datapath: request capture, cursor row/column, sweep pointer, screen RAM
// and result registers. Depends on tcw_pkg and tcw_ram.
`timescale 1ns / 1ps
`default_nettype none

module tcw_dp (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire tcw_pkg::tcw_cmd_type             cmd,
   output tcw_pkg::tcw_status_type               status,
   input  wire logic [tcw_pkg::OP_W-1:0]         req_op,
   input  wire logic [tcw_pkg::CHAR_W-1:0]       req_char_byte,
   input  wire logic [tcw_pkg::REQ_ROW_W-1:0]    req_row,
   input  wire logic [tcw_pkg::REQ_COL_W-1:0]    req_col,
   input  wire logic                             csr_wr_en,
   input  wire logic [tcw_pkg::ATTR_W-1:0]       csr_wr_data,
   output logic      [tcw_pkg::POS_W-1:0]        rsp_cursor_position,
   output logic      [tcw_pkg::CHAR_W-1:0]       rsp_cell_char,
   output logic      [tcw_pkg::ATTR_W-1:0]       rsp_cell_attribute
);

   localparam int AW = tcw_pkg::ADDR_W;
   localparam int RW = tcw_pkg::ROW_W;
   localparam int CW = tcw_pkg::COL_W;

   logic [tcw_pkg::ATTR_W-1:0]    attr_ff;
   tcw_pkg::tcw_op_type           op_ff;
   logic [tcw_pkg::CHAR_W-1:0]    char_ff;
   logic [tcw_pkg::REQ_ROW_W-1:0] req_row_ff;
   logic [tcw_pkg::REQ_COL_W-1:0] req_col_ff;
   logic [RW-1:0]                 row_ff, row_in;
   logic [CW-1:0]                 col_ff, col_in;
   logic [AW-1:0]                 ptr_ff, ptr_in;
   logic [tcw_pkg::CHAR_W-1:0]    cell_char_ff;
   logic [tcw_pkg::ATTR_W-1:0]    cell_attr_ff;

   logic                          wr_en, rd_en;
   logic [AW-1:0]                 wr_addr, rd_addr;
   logic [tcw_pkg::CELL_W-1:0]    wr_data, rd_data;

   logic [AW-1:0]                 cur_idx, req_idx;
   logic [RW-1:0]                 row_sat;
   logic [CW-1:0]                 col_sat;
   logic                          last_col, last_row;

   // Saturate the requested cell to the screen
   assign row_sat = (32'(req_row_ff) > tcw_pkg::ROWS - 1) ?
                    RW'(tcw_pkg::ROWS - 1) : RW'(req_row_ff);
   assign col_sat = (32'(req_col_ff) > tcw_pkg::COLUMNS - 1) ?
                    CW'(tcw_pkg::COLUMNS - 1) : CW'(req_col_ff);

   assign cur_idx  = tcw_pkg::cell_index(row_ff, col_ff);
   assign req_idx  = tcw_pkg::cell_index(row_sat, col_sat);
   assign last_col = (col_ff == CW'(tcw_pkg::COLUMNS - 1));
   assign last_row = (row_ff == RW'(tcw_pkg::ROWS - 1));

   // Status toward the controller
   always_comb begin
      status.op           = op_ff;
      status.is_tab       = (char_ff == tcw_pkg::CH_TAB);
      status.is_newline   = (char_ff == tcw_pkg::CH_NEWLINE);
      status.is_backspace = (char_ff == tcw_pkg::CH_BACKSPACE);
      status.at_last_row  = last_row;
      status.at_last_cell = last_row && last_col;
      status.copy_last    = (ptr_ff == AW'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS - 1));
      status.sweep_last   = (ptr_ff == AW'(tcw_pkg::CELL_COUNT - 1));
   end

   // Cursor, pointer and RAM port steering
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      ptr_in  = ptr_ff;
      wr_en   = 1'b0;
      wr_addr = cur_idx;
      wr_data = {attr_ff, tcw_pkg::CH_SPACE};
      rd_en   = 1'b0;
      rd_addr = req_idx;

      if (cmd.put_char) begin
         wr_en   = 1'b1;
         wr_data = {attr_ff, cmd.put_space ? tcw_pkg::CH_SPACE : char_ff};
         if (last_col) begin
            col_in = '0;
            if (!last_row) begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end

      if (cmd.newline) begin
         col_in = '0;
         if (!last_row) begin
            row_in = row_ff + 1'b1;
         end
      end

      if (cmd.back_step) begin
         if (col_ff != '0) begin
            col_in = col_ff - 1'b1;
         end else if (row_ff != '0) begin
            row_in = row_ff - 1'b1;
            col_in = CW'(tcw_pkg::COLUMNS - 1);
         end
      end

      if (cmd.blank) begin
         wr_en = 1'b1;
      end

      if (cmd.cursor_jump) begin
         row_in = row_sat;
         col_in = col_sat;
      end

      if (cmd.clear_start) begin
         ptr_in = '0;
         row_in = '0;
         col_in = '0;
      end

      if (cmd.clear_write) begin
         wr_en   = 1'b1;
         wr_addr = ptr_ff;
         ptr_in  = ptr_ff + 1'b1;
      end

      // Scroll: read one row below, write the row above
      if (cmd.scroll_prime) begin
         ptr_in  = '0;
         rd_en   = 1'b1;
         rd_addr = AW'(tcw_pkg::COLUMNS);
      end

      if (cmd.scroll_copy) begin
         wr_en   = 1'b1;
         wr_addr = ptr_ff;
         wr_data = {attr_ff, rd_data[tcw_pkg::CHAR_W-1:0]};
         rd_en   = !status.copy_last;
         rd_addr = ptr_ff + AW'(tcw_pkg::COLUMNS + 1);
         ptr_in  = ptr_ff + 1'b1;
      end

      if (cmd.scroll_fill) begin
         wr_en   = 1'b1;
         wr_addr = ptr_ff;
         ptr_in  = ptr_ff + 1'b1;
         if (status.sweep_last) begin
            row_in = RW'(tcw_pkg::ROWS - 1);
            col_in = '0;
         end
      end

      if (cmd.read_issue) begin
         rd_en = 1'b1;
      end
   end

   // Cursor and attribute registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         attr_ff <= tcw_pkg::ATTR_RESET;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
      end
   end

   // Request capture, sweep pointer, read capture and result registers
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.load) begin
         op_ff      <= tcw_pkg::tcw_op_type'(req_op);
         char_ff    <= req_char_byte;
         req_row_ff <= req_row;
         req_col_ff <= req_col;
      end
      if (cmd.read_capture) begin
         cell_char_ff <= rd_data[tcw_pkg::CHAR_W-1:0];
         cell_attr_ff <= rd_data[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
      end
      if (cmd.respond) begin
         rsp_cursor_position <= tcw_pkg::POS_W'(cur_idx);
         if (op_ff == tcw_pkg::OP_READ) begin
            rsp_cell_char      <= cell_char_ff;
            rsp_cell_attribute <= cell_attr_ff;
         end else begin
            rsp_cell_char      <= '0;
            rsp_cell_attribute <= '0;
         end
      end
   end

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_W),
      .DEPTH (tcw_pkg::CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

// ----- rtl/tcw_ctrl.sv -----
// Controller: one-hot state machine that sequences puts, tabs, scrolls,
// clears and reads, and strobes the result. Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   output logic                         rsp_valid,
   output tcw_pkg::tcw_cmd_type         cmd,
   input  wire tcw_pkg::tcw_status_type status
);

   typedef enum logic [13:0] {
      ST_IDLE      = 14'b00000000000001,
      ST_DECODE    = 14'b00000000000010,
      ST_PUT       = 14'b00000000000100,
      ST_NEWLINE   = 14'b00000000001000,
      ST_BACK      = 14'b00000000010000,
      ST_BLANK     = 14'b00000000100000,
      ST_CLEAR     = 14'b00000001000000,
      ST_SC_PRIME  = 14'b00000010000000,
      ST_SC_COPY   = 14'b00000100000000,
      ST_SC_FILL   = 14'b00001000000000,
      ST_SETCUR    = 14'b00010000000000,
      ST_READ      = 14'b00100000000000,
      ST_READ_WAIT = 14'b01000000000000,
      ST_RESP      = 14'b10000000000000
   } tcw_state_type;

   tcw_state_type                 state_ff, state_in;
   logic [tcw_pkg::TAB_W-1:0]     tab_cnt_ff, tab_cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      tab_cnt_in   = tab_cnt_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            tab_cnt_in = '0;
            case (status.op)
               tcw_pkg::OP_PUT: begin
                  if (status.is_tab) begin
                     tab_cnt_in = tcw_pkg::TAB_W'(tcw_pkg::TAB_WIDTH);
                     state_in   = ST_PUT;
                  end else if (status.is_newline) begin
                     state_in = ST_NEWLINE;
                  end else if (status.is_backspace) begin
                     state_in = ST_BACK;
                  end else begin
                     state_in = ST_PUT;
                  end
               end
               tcw_pkg::OP_CLEAR: begin
                  cmd.clear_start = 1'b1;
                  state_in        = ST_CLEAR;
               end
               tcw_pkg::OP_SET: state_in = ST_SETCUR;
               default:         state_in = ST_READ;
            endcase
         end
         // Write one cell and advance; a tab repeats this with spaces
         ST_PUT: begin
            cmd.put_char  = 1'b1;
            cmd.put_space = (tab_cnt_ff != '0);
            if (tab_cnt_ff != '0) begin
               tab_cnt_in = tab_cnt_ff - 1'b1;
            end
            if (status.at_last_cell) begin
               state_in = ST_SC_PRIME;
            end else if (tab_cnt_ff > tcw_pkg::TAB_W'(1)) begin
               state_in = ST_PUT;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_NEWLINE: begin
            cmd.newline = 1'b1;
            state_in    = status.at_last_row ? ST_SC_PRIME : ST_RESP;
         end
         ST_BACK: begin
            cmd.back_step = 1'b1;
            state_in      = ST_BLANK;
         end
         ST_BLANK: begin
            cmd.blank = 1'b1;
            state_in  = ST_RESP;
         end
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_RESP;
            end
         end
         ST_SC_PRIME: begin
            cmd.scroll_prime = 1'b1;
            state_in         = ST_SC_COPY;
         end
         ST_SC_COPY: begin
            cmd.scroll_copy = 1'b1;
            if (status.copy_last) begin
               state_in = ST_SC_FILL;
            end
         end
         // Blank the bottom row, then resume any pending tab spaces
         ST_SC_FILL: begin
            cmd.scroll_fill = 1'b1;
            if (status.sweep_last) begin
               state_in = (tab_cnt_ff != '0) ? ST_PUT : ST_RESP;
            end
         end
         ST_SETCUR: begin
            cmd.cursor_jump = 1'b1;
            state_in        = ST_RESP;
         end
         ST_READ: begin
            cmd.read_issue = 1'b1;
            state_in       = ST_READ_WAIT;
         end
         ST_READ_WAIT: begin
            cmd.read_capture = 1'b1;
            state_in         = ST_RESP;
         end
         ST_RESP: begin
            cmd.respond  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tab_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tab_cnt_ff   <= tab_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/text_console_character_writer.sv -----
// Top level of the text console character writer: controller plus datapath.
// Depends on tcw_pkg, tcw_ctrl, tcw_dp and tcw_ram.
`timescale 1ns / 1ps
`default_nettype none

// A command is taken when start is high and busy is low; exactly one result
// follows, shown for a single cycle with rsp_valid, and the receiver must
// take it then, as it cannot stall the block. Work that walks the screen RAM
// (one port write per cycle) takes longer than a put, newline, backspace, set
// cursor or read: a clear writes every cell, and each scroll moves the rows
// below the top up by one and blanks the bottom row. A new command may be
// issued in the cycle the previous result is strobed.
module text_console_character_writer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [tcw_pkg::OP_W-1:0]      req_op,
   input  wire logic [tcw_pkg::CHAR_W-1:0]    req_char_byte,
   input  wire logic [tcw_pkg::REQ_ROW_W-1:0] req_row,
   input  wire logic [tcw_pkg::REQ_COL_W-1:0] req_col,
   input  wire logic                          csr_wr_en,
   input  wire logic [tcw_pkg::ATTR_W-1:0]    csr_wr_data,
   output logic                               rsp_valid,
   output logic      [tcw_pkg::POS_W-1:0]     rsp_cursor_position,
   output logic      [tcw_pkg::CHAR_W-1:0]    rsp_cell_char,
   output logic      [tcw_pkg::ATTR_W-1:0]    rsp_cell_attribute
);

   tcw_pkg::tcw_cmd_type    cmd;
   tcw_pkg::tcw_status_type status;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   tcw_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_op              (req_op),
      .req_char_byte       (req_char_byte),
      .req_row             (req_row),
      .req_col             (req_col),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cell_char       (rsp_cell_char),
      .rsp_cell_attribute  (rsp_cell_attribute)
   );

endmodule

`default_nettype wire

// ----- rtl/tcw_checker.sv -----
// Port-level checker for the text console character writer, bound to the
// top level. Depends on tcw_pkg and text_console_character_writer.
`timescale 1ns / 1ps
`default_nettype none

module tcw_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic                          rsp_valid,
   input wire logic [tcw_pkg::POS_W-1:0]     rsp_cursor_position
);

   // An accepted beat keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted beat did not raise busy");

   // One result per beat: the strobe is a lone pulse, never held
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // Busy drops exactly when the result is strobed
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid)
      else $error("busy fell without a result");

   // The reported cursor always lies on the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_cursor_position) < tcw_pkg::CELL_COUNT))
      else $error("cursor position beyond the screen");

endmodule

bind text_console_character_writer tcw_checker u_tcw_checker (.*);

`default_nettype wire
